// ===== hdl/spectrum_band_eq_pitch_snap_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the band equaliser and pitch snap block
// Immediate-consequent and next-cycle forms, reset-qualified.
// ----------------------------------------------------------------------------
`ifndef SPECTRUM_BAND_EQ_PITCH_SNAP_ASSERT_SVH
`define SPECTRUM_BAND_EQ_PITCH_SNAP_ASSERT_SVH

// ante holds -> cons holds in the same cycle
`define SBEQ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// ante holds -> cons holds in the next cycle
`define SBEQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/sbeq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbeq_pkg
// Shared constants, word types and the note table of the band equaliser.
// ----------------------------------------------------------------------------
package sbeq_pkg;

  localparam int NUM_BINS   = 512;
  localparam int NOTE_COUNT = 8;

  localparam int BIN_W   = $clog2(NUM_BINS);
  localparam int EDGE_W  = 9;
  localparam int CMP_W   = (BIN_W > EDGE_W) ? BIN_W : EDGE_W;
  localparam int HZ_W    = 11;
  localparam int SHIFT_W = 7;
  localparam int NOTE_W  = $clog2(NOTE_COUNT);

  localparam int HZ_MAX       = 1024;
  localparam int CENTI_PER_HZ = 100;
  localparam int PEAK_W       = 19;
  localparam int CENT_W       = 26;
  localparam int CENTI_W      = 17;
  localparam int DEN_W        = 17;
  localparam int DEN2_W       = DEN_W + 1;
  localparam int NUM_W        = 27;
  localparam int DIV_CNT_W    = $clog2(NUM_W);

  // divide by five: 2^17 = 5 * DIV5_HI + 2, low part by reciprocal
  localparam int DIV5_SPLIT = 17;
  localparam int DIV5_HI    = 26214;
  localparam int DIV5_RECIP = 838861;
  localparam int DIV5_SHIFT = 22;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;

  typedef enum logic [2:0] {
    REG_EDGE_DC_CUT,
    REG_EDGE_LOW_BAND,
    REG_EDGE_BOOST_ONE,
    REG_EDGE_MID_BAND,
    REG_EDGE_BOOST_TWO,
    REG_BIN_HZ,
    REG_MAX_SHIFT
  } reg_idx_t;

  typedef enum logic [1:0] {
    GAIN_ZERO,
    GAIN_FIFTH,
    GAIN_THREE_FIFTHS
  } gain_t;

  typedef struct packed {
    logic        [EDGE_W-1:0]  edge_dc_cut;
    logic        [EDGE_W-1:0]  edge_low_band;
    logic        [EDGE_W-1:0]  edge_boost_one;
    logic        [EDGE_W-1:0]  edge_mid_band;
    logic        [EDGE_W-1:0]  edge_boost_two;
    logic        [HZ_W-1:0]    bin_hz;
    logic        [SHIFT_W-1:0] max_shift;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] bin_re;
    logic signed [31:0] bin_im;
    logic               last_bin;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0]       eq_re;
    logic signed [31:0]       eq_im;
    logic                     frame_done;
    logic        [PEAK_W-1:0] peak_freq_hz;
    logic        [2:0]        note_index;
    logic signed [7:0]        shift_bins;
    logic                     shift_ok;
  } out_word_t;

  typedef struct packed {
    logic signed [31:0]      re;
    logic signed [31:0]      im;
    gain_t                   gain;
    logic                    last;
    logic        [BIN_W-1:0] bin;
  } q_word_t;

  typedef struct packed {
    logic             start;
    logic             ack;
    logic [BIN_W-1:0] bin;
  } pitch_req_t;

  typedef struct packed {
    logic                     done;
    logic        [PEAK_W-1:0] peak_freq_hz;
    logic        [2:0]        note_index;
    logic signed [7:0]        shift_bins;
    logic                     shift_ok;
  } pitch_rsp_t;

  // C-major notes from C4 upward, centihertz
  function automatic logic [CENTI_W-1:0] note_centi(input logic [3:0] idx);
    logic [CENTI_W-1:0] v;
    unique case (idx)
      4'd0:  v = 17'd26163;
      4'd1:  v = 17'd29366;
      4'd2:  v = 17'd32963;
      4'd3:  v = 17'd34923;
      4'd4:  v = 17'd39200;
      4'd5:  v = 17'd44000;
      4'd6:  v = 17'd49388;
      4'd7:  v = 17'd52325;
      4'd8:  v = 17'd58733;
      4'd9:  v = 17'd65925;
      4'd10: v = 17'd69846;
      4'd11: v = 17'd78399;
      4'd12: v = 17'd88000;
      4'd13: v = 17'd98777;
      4'd14: v = 17'd104650;
      4'd15: v = 17'd117466;
    endcase
    return v;
  endfunction

endpackage

// ===== hdl/spectrum_band_eq_pitch_snap.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spectrum_band_eq_pitch_snap
// Band equaliser on a spectrum stream with peak search and pitch snapping.
// ----------------------------------------------------------------------------
// Bins enter on in_* (valid/stall) in bin order, one word per bin, the last
// bin of a frame flagged. Every bin gives one word on out_*: the scaled bin,
// and on the last bin also peak frequency, nearest C-major note and the
// rounded shift in bins towards it.
// A bin passes the queue, the gain pipeline and the output register before
// out_valid. Throughput: one bin per cycle within a frame while out_stall
// is low. The last bin of a frame runs the pitch unit (four set-up steps and
// a 27-step restoring divider); the four-word queue keeps taking bins
// meanwhile, then in_stall rises until the result word is loaded.
// Reset (rst_n, synchronous) loads the register defaults, empties the queue
// and pipeline and clears the bin counter and peak tracker.
// When out_stall is high the output word holds; the pipeline stops behind it
// and in_stall follows once the queue fills. Registers are written through
// psel/penable/pwrite, only while idle: a rule for the user, not enforced.
// ----------------------------------------------------------------------------
module spectrum_band_eq_pitch_snap
  import sbeq_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  in_word_t           in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output out_word_t          out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  cfg_t       cfg;
  logic       q_full;
  logic       q_push;
  q_word_t    q_wr;
  logic       q_pop;
  logic       q_vld;
  q_word_t    q_rd;
  pitch_req_t pitch_req;
  pitch_rsp_t pitch_rsp;

  sbeq_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sbeq_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_word   (q_wr)
  );

  sbeq_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (q_wr),
    .full    (q_full),
    .pop     (q_pop),
    .rd_vld  (q_vld),
    .rd_data (q_rd)
  );

  sbeq_pitch u_pitch (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .req   (pitch_req),
    .rsp   (pitch_rsp)
  );

  sbeq_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_vld     (q_vld),
    .q_word    (q_rd),
    .q_pop     (q_pop),
    .pitch_req (pitch_req),
    .pitch_rsp (pitch_rsp),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== hdl/sbeq_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbeq_regs
// APB-style register file holding band edges, bin rate and shift limit.
// ----------------------------------------------------------------------------
module sbeq_regs
  import sbeq_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg
);

  cfg_t     cfg_r;
  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.edge_dc_cut    <= EDGE_W'(1);
      cfg_r.edge_low_band  <= EDGE_W'(23);
      cfg_r.edge_boost_one <= EDGE_W'(81);
      cfg_r.edge_mid_band  <= EDGE_W'(104);
      cfg_r.edge_boost_two <= EDGE_W'(116);
      cfg_r.bin_hz         <= HZ_W'(86);
      cfg_r.max_shift      <= SHIFT_W'(5);
    end else if (wr_en) begin
      case (idx)
        REG_EDGE_DC_CUT:    cfg_r.edge_dc_cut    <= pwdata[EDGE_W-1:0];
        REG_EDGE_LOW_BAND:  cfg_r.edge_low_band  <= pwdata[EDGE_W-1:0];
        REG_EDGE_BOOST_ONE: cfg_r.edge_boost_one <= pwdata[EDGE_W-1:0];
        REG_EDGE_MID_BAND:  cfg_r.edge_mid_band  <= pwdata[EDGE_W-1:0];
        REG_EDGE_BOOST_TWO: cfg_r.edge_boost_two <= pwdata[EDGE_W-1:0];
        REG_BIN_HZ:         cfg_r.bin_hz         <= pwdata[HZ_W-1:0];
        REG_MAX_SHIFT:      cfg_r.max_shift      <= pwdata[SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_EDGE_DC_CUT:    prdata = PDATA_W'(cfg_r.edge_dc_cut);
      REG_EDGE_LOW_BAND:  prdata = PDATA_W'(cfg_r.edge_low_band);
      REG_EDGE_BOOST_ONE: prdata = PDATA_W'(cfg_r.edge_boost_one);
      REG_EDGE_MID_BAND:  prdata = PDATA_W'(cfg_r.edge_mid_band);
      REG_EDGE_BOOST_TWO: prdata = PDATA_W'(cfg_r.edge_boost_two);
      REG_BIN_HZ:         prdata = PDATA_W'(cfg_r.bin_hz);
      REG_MAX_SHIFT:      prdata = PDATA_W'(cfg_r.max_shift);
      default:            prdata = '0;
    endcase
  end

endmodule

// ===== hdl/sbeq_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbeq_front
// Accepts bin words, counts the bin index and picks the band gain.
// ----------------------------------------------------------------------------
module sbeq_front
  import sbeq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  cfg_t     cfg,
  input  logic     in_valid,
  input  in_word_t in_data,
  output logic     in_stall,
  input  logic     q_full,
  output logic     q_push,
  output q_word_t  q_word
);

  logic [BIN_W-1:0] bin_r;
  logic [BIN_W-1:0] bin_nxt;
  logic [CMP_W-1:0] kc;
  gain_t            gain;

  assign in_stall = q_full;
  assign q_push   = in_valid & ~q_full;
  assign kc       = CMP_W'(bin_r);

  always_comb begin
    priority if (kc <= CMP_W'(cfg.edge_dc_cut))    gain = GAIN_ZERO;
    else if     (kc <= CMP_W'(cfg.edge_low_band))  gain = GAIN_FIFTH;
    else if     (kc <= CMP_W'(cfg.edge_boost_one)) gain = GAIN_THREE_FIFTHS;
    else if     (kc <= CMP_W'(cfg.edge_mid_band))  gain = GAIN_FIFTH;
    else if     (kc <= CMP_W'(cfg.edge_boost_two)) gain = GAIN_THREE_FIFTHS;
    else                                           gain = GAIN_ZERO;
  end

  always_comb begin
    q_word.re   = in_data.bin_re;
    q_word.im   = in_data.bin_im;
    q_word.gain = gain;
    q_word.last = in_data.last_bin;
    q_word.bin  = bin_r;
  end

  always_comb begin
    if (in_data.last_bin || (bin_r == BIN_W'(NUM_BINS - 1))) begin
      bin_nxt = '0;
    end else begin
      bin_nxt = bin_r + BIN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_r <= '0;
    end else if (q_push) begin
      bin_r <= bin_nxt;
    end
  end

endmodule

// ===== hdl/sbeq_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbeq_fifo
// Short queue of classified bin words between front and back.
// ----------------------------------------------------------------------------
`include "spectrum_band_eq_pitch_snap_assert.svh"

module sbeq_fifo
  import sbeq_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  q_word_t wr_data,
  output logic    full,
  input  logic    pop,
  output logic    rd_vld,
  output q_word_t rd_data
);

  q_word_t               mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r;
  logic [FIFO_PTR_W-1:0] rd_ptr_r;
  logic [FIFO_PTR_W:0]   cnt_r;

  assign full    = (cnt_r == (FIFO_PTR_W + 1)'(FIFO_DEPTH));
  assign rd_vld  = (cnt_r != '0);
  assign rd_data = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + FIFO_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + FIFO_PTR_W'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + (FIFO_PTR_W + 1)'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - (FIFO_PTR_W + 1)'(1);
      end
    end
  end

  `SBEQ_ASSERT_IMPL(a_fifo_bound, clk, rst_n, 1'b1, cnt_r <= (FIFO_PTR_W + 1)'(FIFO_DEPTH), "fifo count overflow")
  `SBEQ_ASSERT_IMPL(a_fifo_pop_empty, clk, rst_n, pop, cnt_r != '0, "pop from empty fifo")

endmodule

// ===== hdl/sbeq_pitch.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbeq_pitch
// End-of-frame unit: peak frequency, nearest note, rounded bin shift.
// ----------------------------------------------------------------------------
module sbeq_pitch
  import sbeq_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  pitch_req_t req,
  output pitch_rsp_t rsp
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PEAK,
    ST_CENT,
    ST_NOTE,
    ST_DIFF,
    ST_DIV,
    ST_DONE
  } state_t;

  state_t                state_r;
  logic [BIN_W-1:0]      bin_r;
  logic [HZ_W-1:0]       hz_r;
  logic [PEAK_W-1:0]     peak_r;
  logic [DEN_W-1:0]      den_r;
  logic [CENT_W-1:0]     cent_r;
  logic [NOTE_W-1:0]     note_r;
  logic                  neg_r;
  logic [NUM_W-1:0]      quo_r;
  logic [DEN2_W-1:0]     rem_r;
  logic [DIV_CNT_W-1:0]  cnt_r;

  logic [HZ_W-1:0]       hz_clamp;
  logic [NOTE_W-1:0]     note_cnt;
  logic [CENT_W-1:0]     note_val;
  logic                  diff_neg;
  logic [CENT_W-1:0]     diff_mag;
  logic [DEN2_W-1:0]     den2;
  logic [DEN2_W:0]       trial;
  logic                  trial_ge;
  logic signed [7:0]     sh;
  logic [7:0]            amag;

  always_comb begin
    if (cfg.bin_hz == '0) begin
      hz_clamp = HZ_W'(1);
    end else if (cfg.bin_hz > HZ_W'(HZ_MAX)) begin
      hz_clamp = HZ_W'(HZ_MAX);
    end else begin
      hz_clamp = cfg.bin_hz;
    end
  end

  // a note wins over its lower neighbour once 2t reaches their sum
  always_comb begin
    note_cnt = '0;
    for (int i = 0; i < NOTE_COUNT - 1; i++) begin
      if ({cent_r, 1'b0} >= (NUM_W'(note_centi(4'(i))) + NUM_W'(note_centi(4'(i + 1))))) begin
        note_cnt = note_cnt + NOTE_W'(1);
      end
    end
  end

  assign note_val = CENT_W'(note_centi(4'(note_r)));
  assign diff_neg = cent_r > note_val;
  assign diff_mag = diff_neg ? (cent_r - note_val) : (note_val - cent_r);
  assign den2     = {den_r, 1'b0};
  assign trial    = {rem_r, quo_r[NUM_W-1]};
  assign trial_ge = trial >= (DEN2_W + 1)'(den2);

  always_comb begin
    if (neg_r) begin
      if (quo_r >= NUM_W'(128)) begin
        sh   = -8'sd128;
        amag = 8'd128;
      end else begin
        sh   = -$signed(quo_r[7:0]);
        amag = quo_r[7:0];
      end
    end else begin
      if (quo_r >= NUM_W'(127)) begin
        sh   = 8'sd127;
        amag = 8'd127;
      end else begin
        sh   = $signed(quo_r[7:0]);
        amag = quo_r[7:0];
      end
    end
  end

  always_comb begin
    rsp.done         = (state_r == ST_DONE);
    rsp.peak_freq_hz = peak_r;
    rsp.note_index   = 3'(note_r);
    rsp.shift_bins   = sh;
    rsp.shift_ok     = (amag <= {1'b0, cfg.max_shift});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (req.start) begin
            bin_r   <= req.bin;
            hz_r    <= hz_clamp;
            state_r <= ST_PEAK;
          end
        end
        ST_PEAK: begin
          peak_r  <= PEAK_W'(bin_r * hz_r);
          den_r   <= DEN_W'(hz_r * 7'(CENTI_PER_HZ));
          state_r <= ST_CENT;
        end
        ST_CENT: begin
          cent_r  <= CENT_W'(peak_r * 7'(CENTI_PER_HZ));
          state_r <= ST_NOTE;
        end
        ST_NOTE: begin
          note_r  <= note_cnt;
          state_r <= ST_DIFF;
        end
        ST_DIFF: begin
          neg_r   <= diff_neg;
          quo_r   <= NUM_W'({diff_mag, 1'b0}) + NUM_W'(den_r);
          rem_r   <= '0;
          cnt_r   <= '0;
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          quo_r <= {quo_r[NUM_W-2:0], trial_ge};
          rem_r <= trial_ge ? DEN2_W'(trial - (DEN2_W + 1)'(den2)) : DEN2_W'(trial);
          cnt_r <= cnt_r + DIV_CNT_W'(1);
          if (cnt_r == DIV_CNT_W'(NUM_W - 1)) begin
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (req.ack) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/sbeq_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbeq_back
// Gain pipeline, peak tracking, end-of-frame hand-off and output register.
// ----------------------------------------------------------------------------
`include "spectrum_band_eq_pitch_snap_assert.svh"

module sbeq_back
  import sbeq_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_vld,
  input  q_word_t    q_word,
  output logic       q_pop,
  output pitch_req_t pitch_req,
  input  pitch_rsp_t pitch_rsp,
  output logic       out_valid,
  input  logic       out_stall,
  output out_word_t  out_data
);

  typedef struct packed {
    logic             neg_re;
    logic             neg_im;
    logic             last;
    logic [BIN_W-1:0] bin;
  } tag_t;

  // stage 1: magnitudes
  logic        p1_vld_r;
  tag_t        p1_tag_r;
  gain_t       p1_gain_r;
  logic [31:0] p1_re_r;
  logic [31:0] p1_im_r;
  // stage 2: magnitude times zero, one or three
  logic        p2_vld_r;
  tag_t        p2_tag_r;
  logic [32:0] p2_re_r;
  logic [32:0] p2_im_r;
  // stage 3: split divide by five
  logic        p3_vld_r;
  tag_t        p3_tag_r;
  logic [30:0] p3_hre_r;
  logic [30:0] p3_him_r;
  logic [15:0] p3_lre_r;
  logic [15:0] p3_lim_r;
  // stage 4: signed result
  logic               p4_vld_r;
  tag_t               p4_tag_r;
  logic signed [31:0] p4_re_r;
  logic signed [31:0] p4_im_r;

  logic signed [31:0] best_val_r;
  logic [BIN_W-1:0]   best_bin_r;
  logic               busy_r;
  logic signed [31:0] hold_re_r;
  logic signed [31:0] hold_im_r;
  logic               out_valid_r;
  out_word_t          out_data_r;

  logic             can_load;
  logic             adv;
  logic             load_norm;
  logic             load_pitch;
  logic             start;
  logic             better;
  logic [BIN_W-1:0] best_bin_nxt;
  logic [31:0]      q_re_mag;
  logic [31:0]      q_im_mag;

  function automatic logic [32:0] gain_mul(input logic [31:0] mag, input gain_t g);
    logic [32:0] m;
    case (g)
      GAIN_FIFTH:        m = {1'b0, mag};
      GAIN_THREE_FIFTHS: m = {1'b0, mag} + {mag, 1'b0};
      default:           m = '0;
    endcase
    return m;
  endfunction

  function automatic logic [15:0] low_fifth(input logic [32:0] m);
    logic [17:0] t;
    logic [37:0] p;
    t = 18'({m[32:DIV5_SPLIT], 1'b0}) + 18'(m[DIV5_SPLIT-1:0]);
    p = t * 20'(DIV5_RECIP);
    return p[DIV5_SHIFT+15:DIV5_SHIFT];
  endfunction

  assign q_re_mag = q_word.re[31] ? (~q_word.re + 32'd1) : q_word.re;
  assign q_im_mag = q_word.im[31] ? (~q_word.im + 32'd1) : q_word.im;

  assign can_load   = ~out_valid_r | ~out_stall;
  assign adv        = can_load & ~busy_r;
  assign q_pop      = adv & q_vld;
  assign load_norm  = adv & p4_vld_r & ~p4_tag_r.last;
  assign start      = adv & p4_vld_r & p4_tag_r.last;
  assign load_pitch = busy_r & pitch_rsp.done & can_load;

  assign better       = p4_re_r > best_val_r;
  assign best_bin_nxt = better ? p4_tag_r.bin : best_bin_r;

  assign pitch_req.start = start;
  assign pitch_req.ack   = load_pitch;
  assign pitch_req.bin   = best_bin_nxt;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_tag_r.neg_re <= q_word.re[31];
      p1_tag_r.neg_im <= q_word.im[31];
      p1_tag_r.last   <= q_word.last;
      p1_tag_r.bin    <= q_word.bin;
      p1_gain_r       <= q_word.gain;
      p1_re_r         <= q_re_mag;
      p1_im_r         <= q_im_mag;

      p2_tag_r <= p1_tag_r;
      p2_re_r  <= gain_mul(p1_re_r, p1_gain_r);
      p2_im_r  <= gain_mul(p1_im_r, p1_gain_r);

      p3_tag_r <= p2_tag_r;
      p3_hre_r <= p2_re_r[32:DIV5_SPLIT] * 15'(DIV5_HI);
      p3_him_r <= p2_im_r[32:DIV5_SPLIT] * 15'(DIV5_HI);
      p3_lre_r <= low_fifth(p2_re_r);
      p3_lim_r <= low_fifth(p2_im_r);

      p4_tag_r <= p3_tag_r;
      p4_re_r  <= p3_tag_r.neg_re ? -$signed(32'(p3_hre_r) + 32'(p3_lre_r))
                                  :  $signed(32'(p3_hre_r) + 32'(p3_lre_r));
      p4_im_r  <= p3_tag_r.neg_im ? -$signed(32'(p3_him_r) + 32'(p3_lim_r))
                                  :  $signed(32'(p3_him_r) + 32'(p3_lim_r));
    end
    if (start) begin
      hold_re_r <= p4_re_r;
      hold_im_r <= p4_im_r;
    end
    if (load_norm) begin
      out_data_r.eq_re        <= p4_re_r;
      out_data_r.eq_im        <= p4_im_r;
      out_data_r.frame_done   <= 1'b0;
      out_data_r.peak_freq_hz <= '0;
      out_data_r.note_index   <= '0;
      out_data_r.shift_bins   <= '0;
      out_data_r.shift_ok     <= 1'b0;
    end else if (load_pitch) begin
      out_data_r.eq_re        <= hold_re_r;
      out_data_r.eq_im        <= hold_im_r;
      out_data_r.frame_done   <= 1'b1;
      out_data_r.peak_freq_hz <= pitch_rsp.peak_freq_hz;
      out_data_r.note_index   <= pitch_rsp.note_index;
      out_data_r.shift_bins   <= pitch_rsp.shift_bins;
      out_data_r.shift_ok     <= pitch_rsp.shift_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r    <= 1'b0;
      p2_vld_r    <= 1'b0;
      p3_vld_r    <= 1'b0;
      p4_vld_r    <= 1'b0;
      best_val_r  <= '0;
      best_bin_r  <= '0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        p1_vld_r <= q_vld;
        p2_vld_r <= p1_vld_r;
        p3_vld_r <= p2_vld_r;
        p4_vld_r <= p3_vld_r;
        if (p4_vld_r) begin
          if (p4_tag_r.last) begin
            best_val_r <= '0;
            best_bin_r <= '0;
          end else if (better) begin
            best_val_r <= p4_re_r;
            best_bin_r <= p4_tag_r.bin;
          end
        end
      end
      if (start) begin
        busy_r <= 1'b1;
      end else if (load_pitch) begin
        busy_r <= 1'b0;
      end
      if (load_norm || load_pitch) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  `SBEQ_ASSERT_IMPL(a_start_idle, clk, rst_n, pitch_req.start, !busy_r, "frame end while pitch busy")
  `SBEQ_ASSERT_IMPL(a_done_busy, clk, rst_n, pitch_rsp.done, busy_r, "pitch done without request")
  `SBEQ_ASSERT_NEXT(a_start_busy, clk, rst_n, pitch_req.start, busy_r && !p4_vld_r || busy_r, "busy not set after frame end")

endmodule

// ===== tb/sv/sbeq_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbeq_checker
// Watches the bin, result and register ports of the band equaliser, keeps
// its own copy of the registers, bin counter and peak tracker, predicts the
// word for every bin taken and compares it field by field with the next
// word delivered.
// ----------------------------------------------------------------------------
module sbeq_checker
  import sbeq_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  in_word_t           in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  out_word_t          out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output int                 mismatch_count,
  output int                 words_due
);

  logic [8:0]  edge_dc, edge_low, edge_b1, edge_mid, edge_b2;
  logic [10:0] hz_reg;
  logic [6:0]  shift_lim;

  logic [9:0]         bin_count;
  logic signed [31:0] best_value;
  logic [8:0]         best_bin;

  longint    c_major_centi [0:15];
  out_word_t eq_words_due [$];
  int        fail_tally    = 0;
  int        words_checked = 0;

  initial begin
    c_major_centi = '{26163, 29366, 32963, 34923, 39200, 44000, 49388, 52325,
                      58733, 65925, 69846, 78399, 88000, 98777, 104650, 117466};
  end

  function automatic longint band_scale(longint x, int unsigned k);
    if (k <= edge_dc) return 0;
    if (k <= edge_low) return x / 5;
    if (k <= edge_b1) return (x * 3) / 5;
    if (k <= edge_mid) return x / 5;
    if (k <= edge_b2) return (x * 3) / 5;
    return 0;
  endfunction

  function automatic int closest_note(longint t);
    int n;
    n = (NOTE_COUNT > 16) ? 16 : ((NOTE_COUNT < 1) ? 1 : NOTE_COUNT);
    if (t <= c_major_centi[0]) return 0;
    if (t >= c_major_centi[n-1]) return n - 1;
    for (int i = 0; i + 1 < n; i++) begin
      if (t == c_major_centi[i]) return i;
      if (t > c_major_centi[i] && t < c_major_centi[i+1])
        return (t - c_major_centi[i] >= c_major_centi[i+1] - t) ? i + 1 : i;
    end
    return n - 1;
  endfunction

  task automatic predict_eq_bin(input in_word_t w, output out_word_t r);
    longint      re, im, hz, peak, t, diff, den, mag, q, sh, amag;
    int          note;
    int unsigned k;
    k  = bin_count;
    re = band_scale(longint'(w.bin_re), k);
    im = band_scale(longint'(w.bin_im), k);
    if (re > longint'(best_value)) begin
      best_value = re[31:0];
      best_bin   = k[8:0];
    end
    r       = '0;
    r.eq_re = re[31:0];
    r.eq_im = im[31:0];
    if (w.last_bin) begin
      hz   = (hz_reg == 0) ? 1 : ((hz_reg > 1024) ? 1024 : longint'(hz_reg));
      peak = longint'(best_bin) * hz;
      t    = peak * 100;
      note = closest_note(t);
      diff = c_major_centi[note] - t;
      den  = hz * 100;
      mag  = (diff < 0) ? -diff : diff;
      q    = (mag * 2 + den) / (den * 2);
      sh   = (diff < 0) ? -q : q;
      if (sh > 127) sh = 127;
      if (sh < -128) sh = -128;
      amag = (sh < 0) ? -sh : sh;
      r.frame_done   = 1'b1;
      r.peak_freq_hz = peak[PEAK_W-1:0];
      r.note_index   = 3'(note);
      r.shift_bins   = sh[7:0];
      r.shift_ok     = (amag <= longint'(shift_lim));
      bin_count  = '0;
      best_value = '0;
      best_bin   = '0;
    end else begin
      bin_count = (k + 1 >= NUM_BINS) ? 10'd0 : 10'(k + 1);
    end
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("word %0d %s: got %0h want %0h", words_checked, what, got, want);
    fail_tally++;
  endtask

  always @(posedge clk) begin
    out_word_t predicted, due;
    if (!rst_n) begin
      edge_dc    = 9'd1;
      edge_low   = 9'd23;
      edge_b1    = 9'd81;
      edge_mid   = 9'd104;
      edge_b2    = 9'd116;
      hz_reg     = 11'd86;
      shift_lim  = 7'd5;
      bin_count  = '0;
      best_value = '0;
      best_bin   = '0;
      eq_words_due.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[4:2]))
          REG_EDGE_DC_CUT:    edge_dc   = pwdata[8:0];
          REG_EDGE_LOW_BAND:  edge_low  = pwdata[8:0];
          REG_EDGE_BOOST_ONE: edge_b1   = pwdata[8:0];
          REG_EDGE_MID_BAND:  edge_mid  = pwdata[8:0];
          REG_EDGE_BOOST_TWO: edge_b2   = pwdata[8:0];
          REG_BIN_HZ:         hz_reg    = pwdata[10:0];
          REG_MAX_SHIFT:      shift_lim = pwdata[6:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        predict_eq_bin(in_data, predicted);
        eq_words_due.push_back(predicted);
      end
      if (out_valid && !out_stall) begin
        if (eq_words_due.size() == 0) begin
          report_mismatch("unexpected word", out_data[63:0], '0);
        end else begin
          due = eq_words_due.pop_front();
          if (out_data.eq_re !== due.eq_re)
            report_mismatch("eq_re", out_data.eq_re, due.eq_re);
          if (out_data.eq_im !== due.eq_im)
            report_mismatch("eq_im", out_data.eq_im, due.eq_im);
          if (out_data.frame_done !== due.frame_done)
            report_mismatch("frame_done", out_data.frame_done, due.frame_done);
          if (out_data.peak_freq_hz !== due.peak_freq_hz)
            report_mismatch("peak_freq_hz", out_data.peak_freq_hz, due.peak_freq_hz);
          if (out_data.note_index !== due.note_index)
            report_mismatch("note_index", out_data.note_index, due.note_index);
          if (out_data.shift_bins !== due.shift_bins)
            report_mismatch("shift_bins", out_data.shift_bins, due.shift_bins);
          if (out_data.shift_ok !== due.shift_ok)
            report_mismatch("shift_ok", out_data.shift_ok, due.shift_ok);
        end
        words_checked++;
      end
    end
    words_due      <= eq_words_due.size();
    mismatch_count <= fail_tally;
  end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the band equaliser and pitch snap block: directed
// frames with extreme bins, then many register settings each followed by
// frames of random bins, with random gaps on the bin side and random hold-off
// on the result side. Checking is done by sbeq_checker.
// ----------------------------------------------------------------------------
module tb_top;
  import sbeq_pkg::*;

  localparam int          WATCHDOG_LIMIT  = 2000;
  localparam int          SETTLE_CYCLES   = 48;
  localparam int          RANDOM_ITEMS    = 1250;
  localparam int          PRESSURE_CYCLES = 150;
  localparam logic [2:0]  UNMAPPED_REG    = 3'd7;

  logic               clk      = 1'b0;
  logic               rst_n    = 1'b0;
  logic               in_valid = 1'b0;
  in_word_t           in_data  = '0;
  logic               out_stall = 1'b0;
  logic               psel     = 1'b0;
  logic               penable  = 1'b0;
  logic               pwrite   = 1'b0;
  logic [PADDR_W-1:0] paddr    = '0;
  logic [PDATA_W-1:0] pwdata   = '0;

  logic               in_stall;
  logic               out_valid;
  out_word_t          out_data;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  int mismatch_count;
  int words_due;
  int items_sent = 0;
  int quiet_cycles = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  spectrum_band_eq_pitch_snap u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  sbeq_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .pready         (pready),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .mismatch_count (mismatch_count),
    .words_due      (words_due)
  );

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // result side: random hold-off, plus long holds so the queue fills
  initial begin
    int outs_seen, hold_left, run_left, next_pressure, r;
    outs_seen     = 0;
    hold_left     = 0;
    run_left      = 0;
    next_pressure = 100;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) outs_seen++;
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (rst_n && outs_seen >= next_pressure) begin
        out_stall <= 1'b1;
        hold_left = PRESSURE_CYCLES - 1;
        next_pressure = (next_pressure < 800) ? 800 : 32'h7fffffff;
      end else if (run_left != 0) begin
        out_stall <= 1'b0;
        run_left--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          out_stall <= 1'b0;
          run_left = $urandom_range(0, 6);
        end else if (r < 65) begin
          out_stall <= 1'b0;
          run_left = $urandom_range(40, 200);
        end else if (r < 92) begin
          out_stall <= 1'b1;
          hold_left = $urandom_range(0, 2);
        end else begin
          out_stall <= 1'b1;
          hold_left = $urandom_range(7, 39);
        end
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] make_sample(int mode, bit is_peak);
    case (mode)
      0: return is_peak ? {2'b01, 30'($urandom)} : 32'($urandom_range(0, 131071)) - 32'd65536;
      1: return $urandom;
      2: return {1'b1, 31'($urandom)};
      default: begin
        case ($urandom_range(0, 7))
          0: return 32'h7fffffff;
          1: return 32'h80000000;
          2: return 32'h00000000;
          3: return 32'h00000001;
          4: return 32'hffffffff;
          5: return 32'h00000005;
          6: return 32'hfffffffb;
          default: return $urandom;
        endcase
      end
    endcase
  endfunction

  task automatic send_bin(logic [31:0] re, logic [31:0] im, bit last, int gap);
    in_word_t w;
    w.bin_re   = re;
    w.bin_im   = im;
    w.last_bin = last;
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_frame(int len, int mode, bit burst, int peak_at);
    logic [31:0] im;
    for (int i = 0; i < len; i++) begin
      im = (mode == 3) ? make_sample(3, 1'b0) : $urandom;
      send_bin(make_sample(mode, i == peak_at), im, i == len - 1, burst ? 0 : pick_gap());
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (words_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // upper, unused bits of the word carry junk
  task automatic write_reg(logic [2:0] idx, logic [31:0] value, int width);
    logic [31:0] mask;
    mask = (32'd1 << width) - 1;
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= (value & mask) | ($urandom & ~mask);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_bands(int e0, int e1, int e2, int e3, int e4, int hz, int ms);
    wait_idle();
    write_reg(REG_EDGE_DC_CUT, e0, EDGE_W);
    write_reg(REG_EDGE_LOW_BAND, e1, EDGE_W);
    write_reg(REG_EDGE_BOOST_ONE, e2, EDGE_W);
    write_reg(REG_EDGE_MID_BAND, e3, EDGE_W);
    write_reg(REG_EDGE_BOOST_TWO, e4, EDGE_W);
    write_reg(REG_BIN_HZ, hz, HZ_W);
    write_reg(REG_MAX_SHIFT, ms, SHIFT_W);
  endtask

  task automatic random_bands();
    int e [5];
    int hz, ms, r;
    r = $urandom_range(0, 9);
    for (int i = 0; i < 5; i++) begin
      if (r < 6)
        e[i] = (i == 0) ? $urandom_range(0, 3) : e[i-1] + $urandom_range(0, 40);
      else if (r < 9)
        e[i] = $urandom_range(0, 511);
      else
        e[i] = (i == 0) ? 1 : e[i-1] + $urandom_range(10, 60);
      if (e[i] > 511) e[i] = 511;
    end
    r = $urandom_range(0, 99);
    if (r < 35) hz = $urandom_range(20, 120);
    else if (r < 55) hz = $urandom_range(1, 19);
    else if (r < 70) hz = $urandom_range(121, 1024);
    else if (r < 85) begin
      case ($urandom_range(0, 5))
        0: hz = 0;
        1: hz = 1;
        2: hz = 2;
        3: hz = 1024;
        4: hz = 1025;
        default: hz = 2047;
      endcase
    end else hz = $urandom_range(0, 2047);
    r = $urandom_range(0, 99);
    if (r < 20) ms = 0;
    else if (r < 35) ms = 127;
    else if (r < 80) ms = $urandom_range(0, 15);
    else ms = $urandom_range(0, 127);
    set_bands(e[0], e[1], e[2], e[3], e[4], hz, ms);
  endtask

  initial begin
    int random_start, frames, len, r, mode;
    bit burst;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // extremes on register defaults; peak tie keeps the earlier bin
    send_bin(32'h7fffffff, 32'h80000000, 1'b0, pick_gap());
    send_bin(32'h80000000, 32'h7fffffff, 1'b0, pick_gap());
    send_bin(32'h7fffffff, 32'h00000000, 1'b0, pick_gap());
    send_bin(32'h80000000, 32'hffffffff, 1'b0, pick_gap());
    send_bin(32'h00000001, 32'h7fffffff, 1'b0, pick_gap());
    send_bin(32'h7fffffff, 32'h80000000, 1'b0, pick_gap());
    send_bin(32'hffffffff, 32'h00000001, 1'b0, pick_gap());
    send_bin(32'h00000000, 32'h00000005, 1'b1, pick_gap());
    // one-bin frame, then a frame with no positive real part
    send_bin(32'h80000000, 32'h80000000, 1'b1, pick_gap());
    send_frame(5, 2, 1'b0, -1);
    // peak at 416 Hz, midway between two notes
    wait_idle();
    write_reg(REG_BIN_HZ, 52, HZ_W);
    send_frame(9, 0, 1'b0, 8);

    random_start = items_sent;
    // overlong frame, peak far above the top note
    set_bands(0, 100, 300, 400, 511, 2, 127);
    send_frame(520, 0, 1'b1, 505);
    set_bands(0, 0, 0, 0, 0, 0, 0);
    send_frame(12, 1, 1'b0, -1);
    set_bands(511, 511, 511, 511, 511, 2047, 127);
    send_frame(20, 0, 1'b0, 7);
    set_bands(200, 10, 300, 5, 400, 1, 0);
    write_reg(UNMAPPED_REG, $urandom, 32);
    send_frame(40, 3, 1'b0, -1);

    while (items_sent - random_start < RANDOM_ITEMS) begin
      random_bands();
      frames = $urandom_range(1, 6);
      for (int f = 0; f < frames && items_sent - random_start < RANDOM_ITEMS; f++) begin
        r = $urandom_range(0, 99);
        if (r < 60) len = $urandom_range(1, 24);
        else if (r < 90) len = $urandom_range(25, 130);
        else len = $urandom_range(131, 260);
        r = $urandom_range(0, 99);
        mode = (r < 50) ? 0 : (r < 70) ? 1 : (r < 80) ? 2 : 3;
        burst = ($urandom_range(0, 99) < 30);
        send_frame(len, mode, burst, $urandom_range(0, len - 1));
      end
    end

    in_valid <= 1'b0;
    wait_idle();
    if (mismatch_count == 0 && words_due == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== spectrum_band_eq_pitch_snap.f =====
+incdir+hdl
hdl/sbeq_pkg.sv
hdl/sbeq_regs.sv
hdl/sbeq_front.sv
hdl/sbeq_fifo.sv
hdl/sbeq_pitch.sv
hdl/sbeq_back.sv
hdl/spectrum_band_eq_pitch_snap.sv
tb/sv/sbeq_checker.sv
tb/sv/tb_top.sv
